// ===== sv/overwriting_broadcast_ring_top_defines.svh =====
// Assertion macros for the overwriting broadcast ring.
`ifndef OVERWRITING_BROADCAST_RING_TOP_DEFINES_SVH
`define OVERWRITING_BROADCAST_RING_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, masked while reset is low.
`define OBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obr: implication check failed");

// Next-cycle implication, masked while reset is low.
`define OBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obr: next-cycle check failed");

`else

`define OBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/obr_pkg.sv =====
// Types, constants and helpers shared by the overwriting broadcast ring.
package obr_pkg;

    localparam int DEPTH         = 64;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int CNT_W         = IDX_W + 1;
    localparam int RING_MIN      = 2;
    localparam int PAYLOAD_BYTES = 8;
    localparam int SEQ_W         = 64;
    localparam int DATA_W        = 64;
    localparam int LEN_W         = 4;
    localparam int MODE_W        = 3;
    localparam int STATUS_W      = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 7;
    localparam int MAXP_W        = 4;
    localparam int PCT_SCALE     = 100;

    // Divider: quotient below 128, dividend below 100 * DEPTH.
    localparam int QUO_W  = 7;
    localparam int DVD_W  = 13;
    localparam int STEP_W = 3;

    // Stream payload layout.
    localparam int IN_W          = 136;
    localparam int OUT_W         = 344;
    localparam int OUT_USAGE_LSB = 331;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUBLISH = 3'd0,
        MODE_READ    = 3'd1,
        MODE_PEEK    = 3'd2,
        MODE_LATEST  = 3'd3,
        MODE_OLDEST  = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NO_DATA = 3'd1,
        ST_LOST    = 3'd2,
        ST_INVALID = 3'd3,
        ST_SMALL   = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_COUNT = 1'b0,
        CFG_MAX_PAYLOAD = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MOD,
        S_MOD_WAIT,
        S_PCT,
        S_PCT_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MOD_NONE,
        MOD_WIDX,
        MOD_RIDX
    } t_mod_tgt;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] payload;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
        logic [CNT_W-1:0] remainder;
    } t_div_rsp;

    // Keep the low len bytes of a payload word.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            if (LEN_W'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/obr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module obr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/obr_div.sv =====
// Restoring divider, one quotient bit per cycle, shared for modulo and percent.
module obr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  obr_pkg::t_div_req i_req,
    output obr_pkg::t_div_rsp o_rsp
);

    import obr_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [QUO_W-1:0]  r_dvd, n_dvd;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_div, n_div;
    logic [CNT_W:0]    trial;
    logic              ge;

    assign trial = {r_rem, r_dvd[QUO_W-1]};
    assign ge    = (trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_req.start) begin
            // Upper dividend bits are already below the divisor.
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = CNT_W'(i_req.dividend[DVD_W-1:QUO_W]);
            n_dvd  = i_req.dividend[QUO_W-1:0];
            n_quo  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_rem  = ge ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
            n_dvd  = {r_dvd[QUO_W-2:0], 1'b0};
            n_quo  = {r_quo[QUO_W-2:0], ge};
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(QUO_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== sv/overwriting_broadcast_ring_top.sv =====
// Top level of the overwriting broadcast ring: sequencer, state and stream ports.
//
// One writer publishes short messages into a ring that never blocks it; one
// reader follows by sequence number with read, peek, jump to latest and jump
// to oldest. Requests arrive on the s_axis channel (mode in tuser), one
// result per request leaves on m_axis (status in tuser). The config port
// writes entry_count (index 0) and max_payload_bytes (index 1); the user must
// write them only while idle, as the block itself does not enforce it.
// Items are handled one at a time. From the input transfer an item goes
// through one ring lookup and one evaluation, then any index advance, then the
// shared divider works out the usage percent. A result with full usage skips
// the divider. When an advanced ring index reaches the entry count and has to
// wrap, the same divider reduces it first. s_axis_tready is high only between
// items, so a new item is taken only once the last one has left the sequencer.
// Results sit in an output register; a stalled receiver holds it and the
// next item's result waits in the sequencer until that transfer happens.
// Reset empties the ring (all valid bits cleared at once), sets both
// sequences to one and the totals to zero; no clearing pass is needed.
module overwriting_broadcast_ring_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [obr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [obr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // payload[63:0], length[67:64], stamp[131:68], room[135:132]
    input  logic [obr_pkg::IN_W-1:0]          s_axis_tdata,
    // mode[2:0]
    input  logic [obr_pkg::MODE_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_payload[63:0], out_length[67:64], out_stamp[131:68],
    // out_sequence[195:132], available[202:196], published_total[266:203],
    // overwrite_total[330:267], usage_percent[337:331], zero[343:338]
    output logic [obr_pkg::OUT_W-1:0]         m_axis_tdata,
    // status[2:0]
    output logic [obr_pkg::STATUS_W-1:0]      m_axis_tuser
);

    import obr_pkg::*;

    `include "overwriting_broadcast_ring_top_defines.svh"

    // Sequencer and ring state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_entry_count;
    logic [MAXP_W-1:0] r_max_payload;
    logic [SEQ_W-1:0]  r_wseq, n_wseq;
    logic [IDX_W-1:0]  r_widx, n_widx;
    logic [SEQ_W-1:0]  r_rseq, n_rseq;
    logic [IDX_W-1:0]  r_ridx, n_ridx;
    logic [SEQ_W-1:0]  r_pub, n_pub;
    logic [SEQ_W-1:0]  r_ovw, n_ovw;
    logic [DEPTH-1:0]  r_valid, n_valid;
    t_mod_tgt          r_mod_tgt, n_mod_tgt;
    logic              r_m_valid, n_m_valid;

    // Item and result payload
    logic [MODE_W-1:0] r_mode;
    logic [DATA_W-1:0] r_payload;
    logic [LEN_W-1:0]  r_length;
    logic [DATA_W-1:0] r_stamp;
    logic [LEN_W-1:0]  r_room;
    logic [IDX_W-1:0]  r_idx;
    t_status           r_status, n_status;
    t_entry            r_res, n_res;
    logic [CNT_W-1:0]  r_usage, n_usage;
    logic [CNT_W-1:0]  r_mod_x, n_mod_x;
    logic [OUT_W-1:0]  r_m_data, n_m_data;
    logic [STATUS_W-1:0] r_m_user, n_m_user;

    // Datapath
    logic              accept;
    logic [CNT_W-1:0]  cnt;
    logic [LEN_W-1:0]  lim;
    logic [SEQ_W-1:0]  cnt64;
    logic [SEQ_W-1:0]  oldest_seq;
    logic [SEQ_W-1:0]  used;
    logic [SEQ_W-1:0]  unread;
    logic [CNT_W-1:0]  avail;
    logic [CNT_W-1:0]  widx_inc;
    logic [CNT_W-1:0]  ridx_inc;
    logic              lost;
    logic              peek;
    logic              ent_valid;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    t_entry            ram_wdata;
    t_entry            ram_rdata;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Saturate the configured values into their legal ranges.
    always_comb begin
        if (r_entry_count < CNT_W'(RING_MIN)) begin
            cnt = CNT_W'(RING_MIN);
        end else if (r_entry_count > CNT_W'(DEPTH)) begin
            cnt = CNT_W'(DEPTH);
        end else begin
            cnt = r_entry_count;
        end
        if (r_max_payload == '0) begin
            lim = LEN_W'(1);
        end else if (r_max_payload > MAXP_W'(PAYLOAD_BYTES)) begin
            lim = LEN_W'(PAYLOAD_BYTES);
        end else begin
            lim = r_max_payload;
        end
    end

    assign cnt64      = SEQ_W'(cnt);
    assign oldest_seq = r_wseq - cnt64 + SEQ_W'(1);
    assign lost       = (r_wseq > cnt64) && (r_rseq < (r_wseq - cnt64));
    assign used       = r_pub - r_ovw;
    assign unread     = r_wseq - r_rseq;
    assign widx_inc   = CNT_W'(r_widx) + CNT_W'(1);
    assign ridx_inc   = CNT_W'(r_ridx) + CNT_W'(1);
    assign peek       = (r_mode == MODE_PEEK);
    assign ent_valid  = r_valid[r_idx];
    assign ram_raddr  = (s_axis_tuser == MODE_PUBLISH) ? r_widx : r_ridx;

    always_comb begin
        if (r_rseq >= r_wseq) begin
            avail = '0;
        end else if (unread > cnt64) begin
            avail = cnt;
        end else begin
            avail = unread[CNT_W-1:0];
        end
    end

    always_comb begin
        ram_wdata.seq     = r_wseq;
        ram_wdata.payload = r_payload & byte_mask(r_length);
        ram_wdata.len     = r_length;
        ram_wdata.stamp   = r_stamp;
    end

    obr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    obr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_wseq    = r_wseq;
        n_widx    = r_widx;
        n_rseq    = r_rseq;
        n_ridx    = r_ridx;
        n_pub     = r_pub;
        n_ovw     = r_ovw;
        n_valid   = r_valid;
        n_mod_tgt = r_mod_tgt;
        n_mod_x   = r_mod_x;
        n_status  = r_status;
        n_res     = r_res;
        n_usage   = r_usage;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        ram_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = cnt;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                n_status  = ST_OK;
                n_res     = '0;
                n_mod_tgt = MOD_NONE;
                n_state   = S_MOD;
                unique case (r_mode)
                    MODE_PUBLISH: begin
                        if (r_length == '0 || r_length > lim) begin
                            n_status = ST_INVALID;
                        end else begin
                            ram_we         = 1'b1;
                            n_valid[r_idx] = 1'b1;
                            // Replacing a live entry counts as an overwrite.
                            if (ent_valid && ram_rdata.seq != '0) begin
                                n_ovw = r_ovw + SEQ_W'(1);
                            end
                            n_wseq    = r_wseq + SEQ_W'(1);
                            n_pub     = r_pub + SEQ_W'(1);
                            n_mod_tgt = MOD_WIDX;
                            n_mod_x   = widx_inc;
                        end
                    end
                    MODE_READ, MODE_PEEK: begin
                        priority if (r_room == '0) begin
                            n_status = ST_INVALID;
                        end else if (lost) begin
                            // Resynchronise to the oldest entry still held.
                            n_status = ST_LOST;
                            if (!peek) begin
                                n_rseq    = oldest_seq;
                                n_mod_tgt = MOD_RIDX;
                                n_mod_x   = widx_inc;
                            end
                        end else if (r_rseq >= r_wseq) begin
                            n_status = ST_NO_DATA;
                        end else if (!ent_valid || ram_rdata.seq != r_rseq) begin
                            n_status = ST_LOST;
                            if (!peek) begin
                                n_rseq = r_wseq;
                                n_ridx = r_widx;
                            end
                        end else if (ram_rdata.len > r_room) begin
                            n_status = ST_SMALL;
                        end else begin
                            n_res = ram_rdata;
                            if (!peek) begin
                                n_rseq    = r_rseq + SEQ_W'(1);
                                n_mod_tgt = MOD_RIDX;
                                n_mod_x   = ridx_inc;
                            end
                        end
                    end
                    MODE_LATEST: begin
                        n_rseq = r_wseq;
                        n_ridx = r_widx;
                    end
                    MODE_OLDEST: begin
                        if (r_wseq > cnt64) begin
                            n_rseq    = oldest_seq;
                            n_mod_tgt = MOD_RIDX;
                            n_mod_x   = widx_inc;
                        end else begin
                            n_rseq = SEQ_W'(1);
                            n_ridx = '0;
                        end
                    end
                    default: begin
                        n_status = ST_INVALID;
                    end
                endcase
            end

            S_MOD: begin
                // Advance an index; the divider only runs if it lies past the ring.
                if (r_mod_tgt == MOD_NONE) begin
                    n_state = S_PCT;
                end else if (r_mod_x < cnt) begin
                    if (r_mod_tgt == MOD_WIDX) begin
                        n_widx = r_mod_x[IDX_W-1:0];
                    end else begin
                        n_ridx = r_mod_x[IDX_W-1:0];
                    end
                    n_state = S_PCT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(r_mod_x);
                    n_state          = S_MOD_WAIT;
                end
            end

            S_MOD_WAIT: begin
                if (div_rsp.done) begin
                    if (r_mod_tgt == MOD_WIDX) begin
                        n_widx = div_rsp.remainder[IDX_W-1:0];
                    end else begin
                        n_ridx = div_rsp.remainder[IDX_W-1:0];
                    end
                    n_state = S_PCT;
                end
            end

            S_PCT: begin
                if (used < cnt64) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(used[IDX_W-1:0]) * DVD_W'(PCT_SCALE);
                    n_state          = S_PCT_WAIT;
                end else begin
                    n_usage = CNT_W'(PCT_SCALE);
                    n_state = S_DONE;
                end
            end

            S_PCT_WAIT: begin
                if (div_rsp.done) begin
                    n_usage = div_rsp.quotient;
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // Load the output register once the previous result has gone.
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {(OUT_W - OUT_USAGE_LSB - CNT_W)'(0), r_usage, r_ovw, r_pub,
                                 avail, r_res.seq, r_res.stamp, r_res.len, r_res.payload};
                    n_m_user  = r_status;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= CNT_W'(DEPTH);
            r_max_payload <= MAXP_W'(PAYLOAD_BYTES);
            r_wseq        <= SEQ_W'(1);
            r_widx        <= '0;
            r_rseq        <= SEQ_W'(1);
            r_ridx        <= '0;
            r_pub         <= '0;
            r_ovw         <= '0;
            r_valid       <= '0;
            r_mod_tgt     <= MOD_NONE;
            r_m_valid     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wseq    <= n_wseq;
            r_widx    <= n_widx;
            r_rseq    <= n_rseq;
            r_ridx    <= n_ridx;
            r_pub     <= n_pub;
            r_ovw     <= n_ovw;
            r_valid   <= n_valid;
            r_mod_tgt <= n_mod_tgt;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[CNT_W-1:0];
                    CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[MAXP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode    <= s_axis_tuser;
            r_payload <= s_axis_tdata[63:0];
            r_length  <= s_axis_tdata[67:64];
            r_stamp   <= s_axis_tdata[131:68];
            r_room    <= s_axis_tdata[135:132];
            r_idx     <= ram_raddr;
        end
        r_status <= n_status;
        r_res    <= n_res;
        r_usage  <= n_usage;
        r_mod_x  <= n_mod_x;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    `OBR_ASSERT_NEXT(a_accept_to_eval, i_clk, i_rst_n, accept, r_state == S_EVAL)
    `OBR_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy)
    `OBR_ASSERT_IMP(a_usage_capped, i_clk, i_rst_n, m_axis_tvalid,
                    m_axis_tdata[OUT_USAGE_LSB +: CNT_W] <= CNT_W'(PCT_SCALE))

endmodule

// ===== tb/obr_ring_checker.sv =====
// Checker for the overwriting broadcast ring: mirrors the ring and compares every result.
module obr_ring_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [obr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [obr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_req_valid,
    input  logic                           i_req_ready,
    // payload[63:0], length[67:64], stamp[131:68], room[135:132]
    input  logic [obr_pkg::IN_W-1:0]       i_req_data,
    // mode[2:0]
    input  logic [obr_pkg::MODE_W-1:0]     i_req_mode,
    input  logic                           i_rsp_valid,
    input  logic                           i_rsp_ready,
    // out_payload[63:0], out_length[67:64], out_stamp[131:68],
    // out_sequence[195:132], available[202:196], published_total[266:203],
    // overwrite_total[330:267], usage_percent[337:331], zero[343:338]
    input  logic [obr_pkg::OUT_W-1:0]      i_rsp_data,
    // status[2:0]
    input  logic [obr_pkg::STATUS_W-1:0]   i_rsp_status,
    output int                             o_pending,
    output int                             o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import obr_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] payload;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] stamp;
        logic [SEQ_W-1:0]  seq_no;
        logic [CNT_W-1:0]  available;
        logic [SEQ_W-1:0]  published;
        logic [SEQ_W-1:0]  overwritten;
        logic [6:0]        usage;
    } t_ring_result;

    logic              slot_valid   [DEPTH];
    logic [SEQ_W-1:0]  slot_seq     [DEPTH];
    logic [DATA_W-1:0] slot_payload [DEPTH];
    logic [LEN_W-1:0]  slot_len     [DEPTH];
    logic [DATA_W-1:0] slot_stamp   [DEPTH];
    logic [SEQ_W-1:0]  wr_seq;
    logic [SEQ_W-1:0]  rd_seq;
    logic [SEQ_W-1:0]  pub_total;
    logic [SEQ_W-1:0]  ovw_total;
    int unsigned       wr_idx;
    int unsigned       rd_idx;
    logic [6:0]        ring_cfg;
    logic [MAXP_W-1:0] maxp_cfg;
    t_ring_result      result_q [$];
    t_ring_result      exp_res;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t ring mismatch on %s: got %0h, want %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic void jump_oldest(input int unsigned cnt);
        if (wr_seq > cnt) begin
            rd_seq = wr_seq - cnt + 1;
            rd_idx = (wr_idx + 1) % cnt;
        end else begin
            rd_seq = 1;
            rd_idx = 0;
        end
    endfunction

    // Reader step shared by read and peek; peek restores the position afterwards.
    function automatic t_ring_result fetch_next(input logic [LEN_W-1:0] room,
                                                input int unsigned cnt);
        t_ring_result r;
        int unsigned  i;
        r = '0;
        if (room == 0) begin
            r.status = ST_INVALID;
        end else if (wr_seq > cnt && rd_seq < wr_seq - cnt) begin
            jump_oldest(cnt);
            r.status = ST_LOST;
        end else if (rd_seq >= wr_seq) begin
            r.status = ST_NO_DATA;
        end else begin
            i = rd_idx % DEPTH;
            if (!slot_valid[i] || slot_seq[i] != rd_seq) begin
                rd_seq   = wr_seq;
                rd_idx   = wr_idx;
                r.status = ST_LOST;
            end else if (slot_len[i] > room) begin
                r.status = ST_SMALL;
            end else begin
                r.status  = ST_OK;
                r.payload = slot_payload[i];
                r.length  = slot_len[i];
                r.stamp   = slot_stamp[i];
                r.seq_no  = slot_seq[i];
                rd_seq++;
                rd_idx = (rd_idx + 1) % cnt;
            end
        end
        return r;
    endfunction

    function automatic t_ring_result predict_ring(input logic [MODE_W-1:0] mode,
                                                  input logic [DATA_W-1:0] payload,
                                                  input logic [LEN_W-1:0]  len,
                                                  input logic [DATA_W-1:0] stamp,
                                                  input logic [LEN_W-1:0]  room);
        t_ring_result     r;
        int unsigned      cnt;
        int unsigned      lim;
        int unsigned      w;
        int unsigned      keep_idx;
        logic [SEQ_W-1:0] keep_seq;
        logic [SEQ_W-1:0] used;
        r   = '0;
        cnt = (ring_cfg < RING_MIN) ? RING_MIN : ((ring_cfg > DEPTH) ? DEPTH : ring_cfg);
        lim = (maxp_cfg == 0) ? 1 : ((maxp_cfg > PAYLOAD_BYTES) ? PAYLOAD_BYTES : maxp_cfg);
        case (mode)
            MODE_PUBLISH: begin
                if (len == 0 || len > lim) begin
                    r.status = ST_INVALID;
                end else begin
                    w = wr_idx % DEPTH;
                    if (slot_valid[w] && slot_seq[w] != 0) ovw_total++;
                    slot_valid[w]   = 1'b1;
                    slot_seq[w]     = wr_seq;
                    slot_payload[w] = payload & ((len >= 8) ? {DATA_W{1'b1}}
                                                            : ((64'd1 << (8 * len)) - 64'd1));
                    slot_len[w]     = len;
                    slot_stamp[w]   = stamp;
                    wr_idx = (wr_idx + 1) % cnt;
                    wr_seq++;
                    pub_total++;
                end
            end
            MODE_READ: r = fetch_next(room, cnt);
            MODE_PEEK: begin
                keep_seq = rd_seq;
                keep_idx = rd_idx;
                r        = fetch_next(room, cnt);
                rd_seq   = keep_seq;
                rd_idx   = keep_idx;
            end
            MODE_LATEST: begin
                rd_seq = wr_seq;
                rd_idx = wr_idx;
            end
            MODE_OLDEST: jump_oldest(cnt);
            default: r.status = ST_INVALID;
        endcase
        if (rd_seq >= wr_seq) begin
            r.available = '0;
        end else begin
            r.available = (wr_seq - rd_seq > cnt) ? CNT_W'(cnt) : CNT_W'(wr_seq - rd_seq);
        end
        r.published   = pub_total;
        r.overwritten = ovw_total;
        used          = pub_total - ovw_total;
        r.usage       = (used < cnt) ? 7'((used * PCT_SCALE) / cnt) : 7'(PCT_SCALE);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) slot_valid[k] = 1'b0;
            wr_seq    = 1;
            rd_seq    = 1;
            wr_idx    = 0;
            rd_idx    = 0;
            pub_total = '0;
            ovw_total = '0;
            ring_cfg  = 7'(DEPTH);
            maxp_cfg  = MAXP_W'(PAYLOAD_BYTES);
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ENTRY_COUNT) ring_cfg = i_cfg_data;
                else maxp_cfg = i_cfg_data[MAXP_W-1:0];
            end
            if (i_req_valid && i_req_ready) begin
                result_q.push_back(predict_ring(i_req_mode, i_req_data[63:0],
                                                i_req_data[67:64], i_req_data[131:68],
                                                i_req_data[135:132]));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (result_q.size() == 0) begin
                    report("unrequested result", {61'd0, i_rsp_status}, '0);
                end else begin
                    exp_res = result_q.pop_front();
                    if (i_rsp_status != exp_res.status)
                        report("status", i_rsp_status, exp_res.status);
                    if (i_rsp_data[63:0] != exp_res.payload)
                        report("payload", i_rsp_data[63:0], exp_res.payload);
                    if (i_rsp_data[67:64] != exp_res.length)
                        report("length", i_rsp_data[67:64], exp_res.length);
                    if (i_rsp_data[131:68] != exp_res.stamp)
                        report("stamp", i_rsp_data[131:68], exp_res.stamp);
                    if (i_rsp_data[195:132] != exp_res.seq_no)
                        report("sequence", i_rsp_data[195:132], exp_res.seq_no);
                    if (i_rsp_data[202:196] != exp_res.available)
                        report("available", i_rsp_data[202:196], exp_res.available);
                    if (i_rsp_data[266:203] != exp_res.published)
                        report("published total", i_rsp_data[266:203], exp_res.published);
                    if (i_rsp_data[330:267] != exp_res.overwritten)
                        report("overwrite total", i_rsp_data[330:267], exp_res.overwritten);
                    if (i_rsp_data[OUT_USAGE_LSB +: 7] != exp_res.usage)
                        report("usage", i_rsp_data[OUT_USAGE_LSB +: 7], exp_res.usage);
                end
            end
        end
        o_pending <= result_q.size();
    end

endmodule

// ===== tb/tb_overwriting_broadcast_ring_top.sv =====
// Testbench top for the overwriting broadcast ring: clock, reset, stimulus and verdict.
module tb_overwriting_broadcast_ring_top;
    timeunit 1ns;
    timeprecision 1ps;
    import obr_pkg::*;

    localparam int unsigned      CYCLE_LIMIT     = 400000;
    localparam int unsigned      N_PHASES        = 12;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI  = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic [MODE_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    int          pending;
    int          fail_count;
    int unsigned cycle_count;
    int unsigned cur_lim;
    logic        idle_on;

    overwriting_broadcast_ring_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    obr_ring_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_mode   (s_axis_tuser),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_status (m_axis_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Receiver: stall in random bursts while idling is on.
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Valid stays high on return so the next request can follow without a gap.
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] payload,
                            input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] stamp,
                            input logic [LEN_W-1:0] room);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {room, stamp, len, payload};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_ring();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        drain_ring();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_PAYLOAD) begin
            cur_lim = (value[MAXP_W-1:0] == 0) ? 1 :
                      ((value[MAXP_W-1:0] > PAYLOAD_BYTES) ? PAYLOAD_BYTES : value[MAXP_W-1:0]);
        end
    endtask

    task automatic send_random(input int unsigned pub_pct);
        int unsigned       pick;
        logic [MODE_W-1:0] mode;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  room;
        pick = $urandom_range(0, 99);
        if (pick < pub_pct) begin
            mode = MODE_PUBLISH;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) mode = MODE_READ;
            else if (pick < 80) mode = MODE_PEEK;
            else if (pick < 88) mode = MODE_LATEST;
            else if (pick < 96) mode = MODE_OLDEST;
            else mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end
        // Mostly lengths that publish and rooms that fit; the rest anywhere in the field.
        len  = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(1, cur_lim));
        room = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'(PAYLOAD_BYTES);
        send_req(mode, {$urandom, $urandom}, len, {$urandom, $urandom}, room);
    endtask

    initial begin
        int unsigned n_items;
        int unsigned pub_pct;
        logic [6:0]  ring_n;
        logic [6:0]  plim;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_ENTRY_COUNT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_PUBLISH;
        idle_on       = 1'b0;
        cur_lim       = PAYLOAD_BYTES;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty ring, zero rooms, rejected lengths and unused modes.
        send_req(MODE_READ, '0, 4'd1, '0, 4'd8);
        send_req(MODE_PEEK, '0, 4'd1, '0, 4'd8);
        send_req(MODE_READ, '1, 4'd8, '1, 4'd0);
        send_req(MODE_PEEK, '1, 4'd8, '1, 4'd0);
        send_req(MODE_PUBLISH, '1, 4'd0, '1, 4'd8);
        send_req(MODE_PUBLISH, '1, 4'd15, '1, 4'd15);
        send_req(MODE_UNUSED_LO, '1, 4'd1, '1, 4'd8);
        send_req(MODE_UNUSED_MID, '0, 4'd1, '0, 4'd8);
        send_req(MODE_UNUSED_HI, '1, 4'd15, '1, 4'd15);
        // Publish at the length extremes, then consume.
        send_req(MODE_PUBLISH, '1, 4'd1, '1, 4'd0);
        send_req(MODE_PUBLISH, '1, 4'd8, '0, 4'd0);
        send_req(MODE_PUBLISH, 64'h0123_4567_89AB_CDEF, 4'd4, 64'h55AA_55AA_55AA_55AA, 4'd0);
        send_req(MODE_PEEK, '0, 4'd0, '0, 4'd8);
        send_req(MODE_READ, '0, 4'd0, '0, 4'd1);
        send_req(MODE_READ, '0, 4'd0, '0, 4'd7);
        send_req(MODE_READ, '0, 4'd0, '0, 4'd15);
        send_req(MODE_READ, '0, 4'd0, '0, 4'd8);
        send_req(MODE_READ, '0, 4'd0, '0, 4'd8);
        send_req(MODE_OLDEST, '0, 4'd0, '0, 4'd0);
        send_req(MODE_READ, '0, 4'd0, '0, 4'd8);
        send_req(MODE_LATEST, '0, 4'd0, '0, 4'd0);
        send_req(MODE_READ, '0, 4'd0, '0, 4'd8);
        // Shrink the ring under the writer: stale entry, then overrun.
        write_reg(CFG_ENTRY_COUNT, 7'd2);
        send_req(MODE_OLDEST, '0, 4'd0, '0, 4'd0);
        send_req(MODE_READ, '0, 4'd0, '0, 4'd8);
        repeat (3) send_req(MODE_PUBLISH, {$urandom, $urandom}, 4'd8, {$urandom, $urandom}, 4'd8);
        send_req(MODE_READ, '0, 4'd0, '0, 4'd8);
        send_req(MODE_READ, '0, 4'd0, '0, 4'd8);

        for (int unsigned p = 0; p < N_PHASES; p++) begin
            n_items = 65;
            pub_pct = $urandom_range(35, 75);
            case (p)
                0: begin ring_n = 7'd127; plim = 7'd0;  end
                1: begin ring_n = 7'd1;   plim = 7'd15; end
                2: begin ring_n = 7'd0;   plim = 7'd1;  end
                3: begin ring_n = 7'd3;   plim = 7'd8;  end
                4: begin ring_n = 7'd64;  plim = 7'd5;  pub_pct = 90; n_items = 150; end
                5: begin ring_n = 7'd65;  plim = 7'd2;  end
                default: begin
                    ring_n = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 127))
                                                         : 7'($urandom_range(2, 9));
                    plim   = 7'($urandom_range(0, 127));
                end
            endcase
            write_reg(CFG_ENTRY_COUNT, ring_n);
            write_reg(CFG_MAX_PAYLOAD, plim);
            // No idling in the closing phases.
            idle_on = (p < N_PHASES - 2) ? ($urandom_range(0, 3) != 0) : 1'b0;
            repeat (n_items) send_random(pub_pct);
        end

        drain_ring();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/obr_pkg.sv
sv/obr_ram.sv
sv/obr_div.sv
sv/overwriting_broadcast_ring_top.sv
tb/obr_ring_checker.sv
tb/tb_overwriting_broadcast_ring_top.sv
